/* rtl/krrt_pkg.sv */
package krrt_pkg;

   localparam int SLOT_COUNT = 6;

   typedef logic [7:0] key_type;

   typedef enum logic [2:0] {
      CMD_PRESS       = 3'd0,
      CMD_RELEASE     = 3'd1,
      CMD_SET_MOD     = 3'd2,
      CMD_CLEAR_MOD   = 3'd3,
      CMD_RELEASE_ALL = 3'd4,
      CMD_SYNC        = 3'd5,
      CMD_SEND        = 3'd6
   } cmd_type;

   typedef struct packed {
      logic    load_en;
      cmd_type cmd;
      key_type code;
      logic    hit_any;
   } cell_ctrl_type;

   typedef struct packed {
      logic match_seen;
      logic empty_seen;
      logic diff_seen;
   } chain_type;

endpackage

/* rtl/krrt_if.sv */
interface krrt_req_if;
   logic              valid;
   logic              ready;
   krrt_pkg::cmd_type command;
   krrt_pkg::key_type key_code;

   modport source (output valid, output command, output key_code, input ready);
   modport sink   (input valid, input command, input key_code, output ready);
endinterface

interface krrt_rsp_if;
   logic              valid;
   logic              ready;
   logic              accepted;
   logic              send_due;
   krrt_pkg::key_type report_modifier;
   krrt_pkg::key_type report_key0;
   krrt_pkg::key_type report_key1;
   krrt_pkg::key_type report_key2;
   krrt_pkg::key_type report_key3;
   krrt_pkg::key_type report_key4;
   krrt_pkg::key_type report_key5;

   modport source (output valid, output accepted, output send_due,
                   output report_modifier, output report_key0, output report_key1,
                   output report_key2, output report_key3, output report_key4,
                   output report_key5, input ready);
   modport sink   (input valid, input accepted, input send_due,
                   input report_modifier, input report_key0, input report_key1,
                   input report_key2, input report_key3, input report_key4,
                   input report_key5, output ready);
endinterface

/* rtl/krrt_cell.sv */
module krrt_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  krrt_pkg::cell_ctrl_type ctrl,
   input  krrt_pkg::chain_type     chain_in,
   output krrt_pkg::chain_type     chain_out,
   output krrt_pkg::key_type       report_key
);
   import krrt_pkg::*;

   key_type pend_ff, pend_in;
   key_type rep_ff, rep_in;
   logic    match, empty, diff;

   assign match = (pend_ff == ctrl.code);
   assign empty = (pend_ff == 8'h00);
   assign diff  = (pend_ff != rep_ff);

   assign chain_out.match_seen = chain_in.match_seen | match;
   assign chain_out.empty_seen = chain_in.empty_seen | empty;
   assign chain_out.diff_seen  = chain_in.diff_seen | diff;

   assign report_key = rep_ff;

   always_comb begin
      pend_in = pend_ff;
      rep_in  = rep_ff;
      if (ctrl.load_en) begin
         unique case (ctrl.cmd)
            CMD_PRESS: begin
               if (!ctrl.hit_any && empty && !chain_in.empty_seen) begin
                  pend_in = ctrl.code;
               end
            end
            CMD_RELEASE: begin
               if (match && !chain_in.match_seen) begin
                  pend_in = 8'h00;
               end
            end
            CMD_RELEASE_ALL: begin
               pend_in = 8'h00;
            end
            CMD_SYNC: begin
               if (diff && !chain_in.diff_seen) begin
                  rep_in = pend_ff;
               end
            end
            default: begin
               pend_in = pend_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 8'h00;
         rep_ff  <= 8'h00;
      end else begin
         pend_ff <= pend_in;
         rep_ff  <= rep_in;
      end
   end

endmodule

/* rtl/keyboard_rollover_report_table.sv */
// response: registered, valid in the cycle after the request transaction
// throughput: one transaction per cycle while the response side is ready
// each transaction resolves combinationally through the six-cell slot chain
// reset: synchronous, clears both tables, the modifier bytes and send-pending
module keyboard_rollover_report_table (
   input  logic clock,
   input  logic reset,
   krrt_req_if.sink   req_chan,
   krrt_rsp_if.source rsp_chan
);
   import krrt_pkg::*;

   logic          accept;
   cell_ctrl_type ctrl;
   chain_type     chain [SLOT_COUNT+1];
   key_type       rep_keys [SLOT_COUNT];

   key_type pend_mod_ff, pend_mod_in;
   key_type rep_mod_ff, rep_mod_in;
   logic    send_ff, send_in;
   logic    acc_ff, acc_in;
   logic    rsp_valid_ff, rsp_valid_in;
   logic    mod_diff;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;
   assign mod_diff       = (pend_mod_ff != rep_mod_ff);

   assign chain[0].match_seen = 1'b0;
   assign chain[0].empty_seen = 1'b0;
   assign chain[0].diff_seen  = mod_diff;

   assign ctrl.load_en = accept;
   assign ctrl.cmd     = req_chan.command;
   assign ctrl.code    = req_chan.key_code;
   assign ctrl.hit_any = chain[SLOT_COUNT].match_seen;

   for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_cell
      krrt_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .chain_in   (chain[i]),
         .chain_out  (chain[i+1]),
         .report_key (rep_keys[i])
      );
   end

   always_comb begin
      pend_mod_in = pend_mod_ff;
      rep_mod_in  = rep_mod_ff;
      send_in     = send_ff;
      acc_in      = acc_ff;
      if (accept) begin
         unique case (req_chan.command)
            CMD_PRESS: begin
               acc_in = chain[SLOT_COUNT].match_seen | chain[SLOT_COUNT].empty_seen;
            end
            CMD_RELEASE: begin
               acc_in = chain[SLOT_COUNT].match_seen;
            end
            CMD_SET_MOD: begin
               pend_mod_in = pend_mod_ff | req_chan.key_code;
               acc_in      = 1'b1;
            end
            CMD_CLEAR_MOD: begin
               pend_mod_in = pend_mod_ff & ~req_chan.key_code;
               acc_in      = 1'b1;
            end
            CMD_RELEASE_ALL: begin
               pend_mod_in = 8'h00;
               acc_in      = 1'b1;
            end
            CMD_SYNC: begin
               if (mod_diff) begin
                  rep_mod_in = pend_mod_ff;
               end
               if (chain[SLOT_COUNT].diff_seen) begin
                  send_in = 1'b1;
               end
               acc_in = chain[SLOT_COUNT].diff_seen;
            end
            CMD_SEND: begin
               acc_in  = send_ff;
               send_in = 1'b0;
            end
            default: begin
               acc_in = 1'b0;
            end
         endcase
      end
   end

   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_mod_ff  <= 8'h00;
         rep_mod_ff   <= 8'h00;
         send_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pend_mod_ff  <= pend_mod_in;
         rep_mod_ff   <= rep_mod_in;
         send_ff      <= send_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.accepted        = acc_ff;
   assign rsp_chan.send_due        = send_ff;
   assign rsp_chan.report_modifier = rep_mod_ff;
   assign rsp_chan.report_key0     = rep_keys[0];
   assign rsp_chan.report_key1     = rep_keys[1];
   assign rsp_chan.report_key2     = rep_keys[2];
   assign rsp_chan.report_key3     = rep_keys[3];
   assign rsp_chan.report_key4     = rep_keys[4];
   assign rsp_chan.report_key5     = rep_keys[5];

   a_sync_raises_send: assert property (@(posedge clock) disable iff (reset)
      accept && req_chan.command == CMD_SYNC && chain[SLOT_COUNT].diff_seen
      |=> send_ff && acc_ff)
      else $error("sync copy did not raise send-pending");

   a_send_clears: assert property (@(posedge clock) disable iff (reset)
      accept && req_chan.command == CMD_SEND |=> !send_ff && acc_ff == $past(send_ff))
      else $error("send did not clear send-pending");

   a_release_all: assert property (@(posedge clock) disable iff (reset)
      accept && req_chan.command == CMD_RELEASE_ALL |=> pend_mod_ff == 8'h00 && acc_ff)
      else $error("release all left modifiers set");

   a_mod_sync: assert property (@(posedge clock) disable iff (reset)
      accept && req_chan.command == CMD_SYNC |=> rep_mod_ff == $past(pend_mod_ff))
      else $error("sync left reported modifiers stale");

endmodule

/* tb/keyboard_rollover_report_table_test.sv */
module keyboard_rollover_report_table_test;
   import krrt_pkg::*;

   localparam cmd_type CMD_UNUSED    = cmd_type'(3'd7);
   localparam int      RANDOM_EVENTS = 1450;
   localparam int      STALL_LIMIT   = 2000;

   typedef struct {
      cmd_type command;
      key_type key_code;
      bit      drain_first;
   } key_event_type;

   typedef struct {
      logic    accepted;
      logic    send_due;
      key_type modifier;
      key_type keys [SLOT_COUNT];
   } hid_report_type;

   logic clock;
   logic reset;

   krrt_req_if req_chan ();
   krrt_rsp_if rsp_chan ();

   keyboard_rollover_report_table dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // shadow of the pending and reported reports
   key_type     held_keys [SLOT_COUNT];
   key_type     held_modifiers;
   key_type     shown_keys [SLOT_COUNT];
   key_type     shown_modifiers;
   logic        send_flag;

   key_event_type  key_events [$];
   hid_report_type expected_reports [$];

   int          total_events;
   int          checked_reports = 0;
   int          mismatch_count  = 0;
   int          quiet_cycles    = 0;
   bit          request_taken   = 1'b0;
   int          burst_left      = 8;
   int          gap_left        = 0;
   int          stall_bits_left = 0;
   logic [15:0] stall_pattern   = '0;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic hid_report_type apply_key_event(key_event_type ev);
      hid_report_type rep;
      logic           hit;
      hit = 1'b0;
      case (ev.command)
         CMD_PRESS: begin
            foreach (held_keys[i])
               if (held_keys[i] == ev.key_code) hit = 1'b1;
            foreach (held_keys[i])
               if (!hit && held_keys[i] == 8'h00) begin
                  held_keys[i] = ev.key_code;
                  hit = 1'b1;
               end
         end
         CMD_RELEASE: begin
            foreach (held_keys[i])
               if (!hit && held_keys[i] == ev.key_code) begin
                  held_keys[i] = 8'h00;
                  hit = 1'b1;
               end
         end
         CMD_SET_MOD: begin
            held_modifiers = held_modifiers | ev.key_code;
            hit = 1'b1;
         end
         CMD_CLEAR_MOD: begin
            held_modifiers = held_modifiers & ~ev.key_code;
            hit = 1'b1;
         end
         CMD_RELEASE_ALL: begin
            foreach (held_keys[i]) held_keys[i] = 8'h00;
            held_modifiers = 8'h00;
            hit = 1'b1;
         end
         CMD_SYNC: begin
            // only the first differing field moves across
            if (shown_modifiers != held_modifiers) begin
               shown_modifiers = held_modifiers;
               hit = 1'b1;
            end else begin
               foreach (shown_keys[i])
                  if (!hit && shown_keys[i] != held_keys[i]) begin
                     shown_keys[i] = held_keys[i];
                     hit = 1'b1;
                  end
            end
            if (hit) send_flag = 1'b1;
         end
         CMD_SEND: begin
            hit = send_flag;
            send_flag = 1'b0;
         end
         default: hit = 1'b0;
      endcase
      rep.accepted = hit;
      rep.send_due = send_flag;
      rep.modifier = shown_modifiers;
      rep.keys     = shown_keys;
      return rep;
   endfunction

   function automatic key_type pick_code();
      case ($urandom_range(0, 9))
         0:       return 8'h00;
         1, 2:    return key_type'($urandom_range(0, 255));
         default: return key_type'(8'h04 + $urandom_range(0, 9));
      endcase
   endfunction

   task automatic push_event(cmd_type command, key_type key_code, bit drain_first);
      key_event_type ev;
      ev.command     = command;
      ev.key_code    = key_code;
      ev.drain_first = drain_first;
      key_events.push_back(ev);
   endtask

   task automatic report_mismatch(string msg);
      $display("mismatch at transaction %0d: %s", checked_reports, msg);
      mismatch_count++;
   endtask

   // request driver and response stall pattern
   always @(negedge clock) begin
      logic next_valid;
      if (reset) begin
         req_chan.valid <= 1'b0;
         rsp_chan.ready <= 1'b0;
      end else begin
         if (!req_chan.valid || request_taken) begin
            next_valid = 1'b0;
            if (gap_left > 0) begin
               gap_left--;
            end else if (key_events.size() > 0 &&
                         !(key_events[0].drain_first && expected_reports.size() > 0)) begin
               req_chan.command  <= key_events[0].command;
               req_chan.key_code <= key_events[0].key_code;
               void'(key_events.pop_front());
               next_valid = 1'b1;
               if (burst_left > 1) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(1, 24);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
               end
            end
            req_chan.valid <= next_valid;
         end
         if (stall_bits_left == 0) begin
            stall_pattern   = ($urandom_range(0, 3) == 0) ? 16'hffff : 16'($urandom);
            stall_bits_left = 16;
         end
         rsp_chan.ready <= stall_pattern[0];
         stall_pattern = stall_pattern >> 1;
         stall_bits_left--;
      end
   end

   // monitor, checker and watchdog
   always @(posedge clock) begin
      hid_report_type want;
      key_event_type  ev;
      key_type        got_keys [SLOT_COUNT];
      if (reset) begin
         foreach (held_keys[i]) begin
            held_keys[i]  = 8'h00;
            shown_keys[i] = 8'h00;
         end
         held_modifiers  = 8'h00;
         shown_modifiers = 8'h00;
         send_flag       = 1'b0;
         request_taken   = 1'b0;
         quiet_cycles    = 0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            got_keys = '{rsp_chan.report_key0, rsp_chan.report_key1, rsp_chan.report_key2,
                         rsp_chan.report_key3, rsp_chan.report_key4, rsp_chan.report_key5};
            if (expected_reports.size() == 0) begin
               report_mismatch("response transaction with nothing outstanding");
            end else begin
               want = expected_reports.pop_front();
               if (rsp_chan.accepted !== want.accepted)
                  report_mismatch($sformatf("accepted got %b expected %b",
                                            rsp_chan.accepted, want.accepted));
               if (rsp_chan.send_due !== want.send_due)
                  report_mismatch($sformatf("send_due got %b expected %b",
                                            rsp_chan.send_due, want.send_due));
               if (rsp_chan.report_modifier !== want.modifier)
                  report_mismatch($sformatf("report_modifier got %h expected %h",
                                            rsp_chan.report_modifier, want.modifier));
               foreach (got_keys[i])
                  if (got_keys[i] !== want.keys[i])
                     report_mismatch($sformatf("report_key%0d got %h expected %h",
                                               i, got_keys[i], want.keys[i]));
            end
            checked_reports++;
         end
         request_taken = req_chan.valid && req_chan.ready;
         if (request_taken) begin
            ev.command     = req_chan.command;
            ev.key_code    = req_chan.key_code;
            ev.drain_first = 1'b0;
            expected_reports.push_back(apply_key_event(ev));
         end
         if (request_taken || (rsp_chan.valid && rsp_chan.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("keyboard_rollover_report_table_test: done, errors");
            $finish;
         end
      end
   end

   initial begin
      int pick;
      reset             = 1'b1;
      req_chan.valid    = 1'b0;
      req_chan.command  = CMD_PRESS;
      req_chan.key_code = 8'h00;
      rsp_chan.ready    = 1'b0;

      // empty table corner cases
      push_event(CMD_PRESS,       8'h00, 1'b0);
      push_event(CMD_RELEASE,     8'h00, 1'b0);
      push_event(CMD_SYNC,        8'h00, 1'b0);
      push_event(CMD_SEND,        8'h00, 1'b0);
      // fill all six slots, then overflow
      push_event(CMD_PRESS,       8'hff, 1'b0);
      push_event(CMD_PRESS,       8'h01, 1'b0);
      push_event(CMD_PRESS,       8'h80, 1'b0);
      push_event(CMD_PRESS,       8'h7f, 1'b0);
      push_event(CMD_PRESS,       8'h2a, 1'b0);
      push_event(CMD_PRESS,       8'h55, 1'b0);
      push_event(CMD_PRESS,       8'haa, 1'b0);
      push_event(CMD_PRESS,       8'h00, 1'b0);
      push_event(CMD_RELEASE,     8'h00, 1'b0);
      push_event(CMD_PRESS,       8'h80, 1'b0);
      // modifiers, sync and send
      push_event(CMD_SET_MOD,     8'hff, 1'b0);
      push_event(CMD_CLEAR_MOD,   8'h0f, 1'b0);
      push_event(CMD_SYNC,        8'h00, 1'b0);
      push_event(CMD_SYNC,        8'h00, 1'b0);
      push_event(CMD_SEND,        8'h00, 1'b0);
      push_event(CMD_SEND,        8'h00, 1'b0);
      push_event(CMD_RELEASE,     8'h33, 1'b0);
      push_event(CMD_RELEASE,     8'h01, 1'b0);
      push_event(CMD_UNUSED,      8'hff, 1'b0);
      push_event(CMD_RELEASE_ALL, 8'h00, 1'b0);
      push_event(CMD_SYNC,        8'h00, 1'b0);

      for (int n = 0; n < RANDOM_EVENTS; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 30)
            push_event(CMD_PRESS, pick_code(), n % 300 == 0);
         else if (pick < 50)
            push_event(CMD_RELEASE, pick_code(), n % 300 == 0);
         else if (pick < 58)
            push_event(CMD_SET_MOD, key_type'($urandom_range(0, 255)), n % 300 == 0);
         else if (pick < 64)
            push_event(CMD_CLEAR_MOD, key_type'($urandom_range(0, 255)), n % 300 == 0);
         else if (pick < 67)
            push_event(CMD_RELEASE_ALL, pick_code(), n % 300 == 0);
         else if (pick < 87)
            push_event(CMD_SYNC, pick_code(), n % 300 == 0);
         else if (pick < 96)
            push_event(CMD_SEND, pick_code(), n % 300 == 0);
         else
            push_event(cmd_type'($urandom_range(0, 7)), key_type'($urandom_range(0, 255)),
                       n % 300 == 0);
      end
      total_events = key_events.size();

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (checked_reports < total_events)
         @(negedge clock);
      repeat (4) @(posedge clock);

      if (mismatch_count == 0)
         $display("keyboard_rollover_report_table_test: done, clean");
      else
         $display("keyboard_rollover_report_table_test: done, errors");
      $finish;
   end

endmodule
